[design/nsht_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsht_pkg
// Shared types and constants of the nearest station handover table.
// ----------------------------------------------------------------------------
package nsht_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 8;
   localparam int DEFAULT_COORD_BITS  = 16;

   localparam int ID_BITS    = 32;
   localparam int POS_BITS   = 16;
   localparam int DIST_BITS  = 17;
   localparam int SLOT_BITS  = 3;
   localparam int MODE_BITS  = 2;

   localparam logic [DIST_BITS-1:0] THRESHOLD_RESET = 17'd100;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_ADD   = 2'd0,
      MODE_SERVE = 2'd1,
      MODE_QUERY = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture the accepted item
      logic dup_step;    // compare one table entry with the item id
      logic write_entry; // store the item at the cursor
      logic set_serving;
      logic dist_start;  // start a distance for the selected point
      logic dist_serving;// distance target is the serving station
      logic dist_take;   // fold the finished distance into the result
      logic entry_next;  // advance the scan index
      logic clear_idx;
      logic out_load;    // build the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic dist_done;
      logic scan_end;    // scan index reached stored count
   } stat_type;

endpackage
`default_nettype wire

[design/nsht_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsht_datapath
// Station table, serving registers, bit-serial distance unit and result build.
// ----------------------------------------------------------------------------
module nsht_datapath #(
   parameter int TABLE_DEPTH = nsht_pkg::DEFAULT_TABLE_DEPTH,
   parameter int COORD_BITS  = nsht_pkg::DEFAULT_COORD_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire nsht_pkg::cmd_type              cmd,
   output nsht_pkg::stat_type                  stat,
   input  wire logic [nsht_pkg::MODE_BITS-1:0] req_mode,
   input  wire logic [nsht_pkg::ID_BITS-1:0]   req_station_id,
   input  wire logic signed [nsht_pkg::POS_BITS-1:0] req_pos_x,
   input  wire logic signed [nsht_pkg::POS_BITS-1:0] req_pos_y,
   input  wire logic [nsht_pkg::DIST_BITS-1:0] threshold,
   output logic                                rsp_status,
   output logic                                rsp_switch_needed,
   output logic                                rsp_better_found,
   output logic [nsht_pkg::SLOT_BITS-1:0]      rsp_best_slot,
   output logic [nsht_pkg::ID_BITS-1:0]        rsp_best_id,
   output logic signed [nsht_pkg::POS_BITS-1:0] rsp_best_x,
   output logic signed [nsht_pkg::POS_BITS-1:0] rsp_best_y,
   output logic [nsht_pkg::DIST_BITS-1:0]      rsp_serving_distance
);
   import nsht_pkg::*;

   localparam int IDX_BITS  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int SQ_BITS   = 2 * DIFF_BITS + 1;
   localparam int ROOT_BITS = (SQ_BITS + 1) / 2;
   localparam int RAD_BITS  = 2 * ROOT_BITS;
   localparam int STEP_BITS = $clog2(ROOT_BITS + 1);
   localparam int MUL_BITS  = 2 * DIFF_BITS;

   logic [ID_BITS-1:0]          ids_ff [TABLE_DEPTH];
   logic signed [COORD_BITS-1:0] xs_ff [TABLE_DEPTH];
   logic signed [COORD_BITS-1:0] ys_ff [TABLE_DEPTH];

   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [IDX_BITS-1:0] cursor_ff, cursor_in;
   logic signed [COORD_BITS-1:0] srv_x_ff, srv_y_ff;

   logic [MODE_BITS-1:0]  mode_ff;
   logic [ID_BITS-1:0]    id_ff;
   logic signed [COORD_BITS-1:0] px_ff, py_ff;

   logic [CNT_BITS-1:0] idx_ff;
   logic [IDX_BITS-1:0] idx_sel;
   logic                dup_ff;

   logic [DIST_BITS-1:0] sdist_ff, best_ff;
   logic                 found_ff;
   logic [IDX_BITS-1:0]  slot_ff;

   // distance unit: squares dx and dy, then one root bit per cycle
   logic [1:0]            phase_ff;
   logic [DIFF_BITS-1:0]  dx_ff, dy_ff;
   logic [MUL_BITS-1:0]   sqa_ff;
   logic [RAD_BITS-1:0]   rem_ff;
   logic [ROOT_BITS-1:0]  root_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic                  busy_ff, done_ff;
   logic signed [COORD_BITS:0] tx, ty, dxs, dys;
   logic [RAD_BITS-1:0]   trial, rem_sh;
   logic [MUL_BITS-1:0]   sq_mul;
   logic [DIFF_BITS-1:0]  mul_op;

   assign idx_sel = idx_ff[IDX_BITS-1:0];

   always_comb begin
      if (cmd.dist_serving) begin
         tx = {srv_x_ff[COORD_BITS-1], srv_x_ff};
         ty = {srv_y_ff[COORD_BITS-1], srv_y_ff};
      end else begin
         tx = {xs_ff[idx_sel][COORD_BITS-1], xs_ff[idx_sel]};
         ty = {ys_ff[idx_sel][COORD_BITS-1], ys_ff[idx_sel]};
      end
      dxs = {px_ff[COORD_BITS-1], px_ff} - tx;
      dys = {py_ff[COORD_BITS-1], py_ff} - ty;
      mul_op = (phase_ff == 2'd1) ? dx_ff : dy_ff;
      sq_mul = mul_op * mul_op;
      rem_sh = {rem_ff[RAD_BITS-3:0], 2'b00};
      trial  = {{(RAD_BITS-ROOT_BITS-2){1'b0}}, root_ff, 2'b01};
   end

   logic [RAD_BITS-1:0] radicand_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.dist_start) begin
            busy_ff  <= 1'b1;
            phase_ff <= 2'd1;
            dx_ff <= dxs[COORD_BITS] ? DIFF_BITS'(-dxs) : DIFF_BITS'(dxs);
            dy_ff <= dys[COORD_BITS] ? DIFF_BITS'(-dys) : DIFF_BITS'(dys);
         end else if (busy_ff) begin
            unique case (phase_ff)
               2'd1: begin
                  sqa_ff   <= sq_mul;
                  phase_ff <= 2'd2;
               end
               2'd2: begin
                  radicand_ff <= RAD_BITS'(sqa_ff) + RAD_BITS'(sq_mul);
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  step_ff  <= STEP_BITS'(ROOT_BITS);
                  phase_ff <= 2'd3;
               end
               2'd3: begin
                  // restoring root: bring down two radicand bits each step
                  if ((rem_sh | RAD_BITS'(radicand_ff[RAD_BITS-1 -: 2])) >= trial) begin
                     rem_ff  <= (rem_sh | RAD_BITS'(radicand_ff[RAD_BITS-1 -: 2])) - trial;
                     root_ff <= {root_ff[ROOT_BITS-2:0], 1'b1};
                  end else begin
                     rem_ff  <= rem_sh | RAD_BITS'(radicand_ff[RAD_BITS-1 -: 2]);
                     root_ff <= {root_ff[ROOT_BITS-2:0], 1'b0};
                  end
                  radicand_ff <= {radicand_ff[RAD_BITS-3:0], 2'b00};
                  step_ff <= step_ff - 1'b1;
                  if (step_ff == STEP_BITS'(1)) begin
                     busy_ff  <= 1'b0;
                     done_ff  <= 1'b1;
                     phase_ff <= 2'd0;
                  end
               end
               default: phase_ff <= 2'd0;
            endcase
         end
      end
   end

   assign stat.dist_done = done_ff;
   assign stat.scan_end  = (idx_ff >= count_ff);

   logic [DIST_BITS-1:0] dist_now;
   assign dist_now = DIST_BITS'(root_ff);

   // table and control registers
   always_comb begin
      count_in  = count_ff;
      cursor_in = cursor_ff;
      if (cmd.write_entry && !dup_ff) begin
         if (count_ff < CNT_BITS'(TABLE_DEPTH)) count_in = count_ff + 1'b1;
         if (cursor_ff == IDX_BITS'(TABLE_DEPTH - 1)) cursor_in = '0;
         else cursor_in = cursor_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cursor_ff <= '0;
         srv_x_ff  <= '0;
         srv_y_ff  <= '0;
         idx_ff    <= '0;
         dup_ff    <= 1'b0;
      end else begin
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         if (cmd.set_serving) begin
            srv_x_ff <= px_ff;
            srv_y_ff <= py_ff;
         end
         if (cmd.clear_idx) begin
            idx_ff <= '0;
            dup_ff <= 1'b0;
         end else if (cmd.entry_next) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.dup_step && ids_ff[idx_sel] == id_ff) dup_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_entry && !dup_ff) begin
         ids_ff[cursor_ff] <= id_ff;
         xs_ff[cursor_ff]  <= px_ff;
         ys_ff[cursor_ff]  <= py_ff;
      end
      if (cmd.load) begin
         mode_ff <= req_mode;
         id_ff   <= req_station_id;
         px_ff   <= COORD_BITS'(req_pos_x);
         py_ff   <= COORD_BITS'(req_pos_y);
      end
      if (cmd.dist_take) begin
         if (cmd.dist_serving) begin
            sdist_ff <= dist_now;
            best_ff  <= dist_now;
            found_ff <= 1'b0;
            slot_ff  <= '0;
         end else if (best_ff > dist_now) begin
            best_ff  <= dist_now;
            found_ff <= 1'b1;
            slot_ff  <= idx_sel;
         end
      end
      if (cmd.out_load) begin
         rsp_status           <= 1'b0;
         rsp_switch_needed    <= 1'b0;
         rsp_better_found     <= 1'b0;
         rsp_best_slot        <= '0;
         rsp_best_id          <= '0;
         rsp_best_x           <= '0;
         rsp_best_y           <= '0;
         rsp_serving_distance <= '0;
         if (mode_ff == MODE_ADD) begin
            rsp_status <= dup_ff;
         end else if (mode_ff == MODE_QUERY) begin
            rsp_switch_needed    <= (sdist_ff >= threshold);
            rsp_serving_distance <= sdist_ff;
            if (found_ff) begin
               rsp_better_found <= 1'b1;
               rsp_best_slot    <= SLOT_BITS'(slot_ff);
               rsp_best_id      <= ids_ff[slot_ff];
               rsp_best_x       <= POS_BITS'(xs_ff[slot_ff]);
               rsp_best_y       <= POS_BITS'(ys_ff[slot_ff]);
            end
         end
      end
   end

endmodule
`default_nettype wire

[design/nsht_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsht_ctrl
// Sequencer: duplicate scan, table write, serving update, serving distance and query scan.
// ----------------------------------------------------------------------------
module nsht_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [nsht_pkg::MODE_BITS-1:0] req_mode,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output nsht_pkg::cmd_type                   cmd,
   input  wire nsht_pkg::stat_type             stat
);
   import nsht_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DUP, ST_SRV_START, ST_SRV_WAIT, ST_SCAN_START, ST_SCAN_WAIT,
      ST_FINISH
   } state_type;

   state_type state_ff;
   mode_type  mode_ff;
   logic      out_full_ff;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = out_full_ff;

   always_comb begin
      cmd = '0;
      cmd.load = accept;
      cmd.clear_idx = accept;
      unique case (state_ff)
         ST_IDLE: ;
         ST_DUP: begin
            if (!stat.scan_end) begin
               cmd.dup_step   = 1'b1;
               cmd.entry_next = 1'b1;
            end
         end
         ST_SRV_START: begin
            cmd.dist_start   = 1'b1;
            cmd.dist_serving = 1'b1;
         end
         ST_SRV_WAIT: begin
            cmd.dist_serving = 1'b1;
            cmd.dist_take    = stat.dist_done;
         end
         ST_SCAN_START: cmd.dist_start = !stat.scan_end;
         ST_SCAN_WAIT: begin
            cmd.dist_take  = stat.dist_done;
            cmd.entry_next = stat.dist_done;
         end
         ST_FINISH: begin
            // the table write of a new id happens once, on the cycle the result is loaded
            cmd.write_entry = (mode_ff == MODE_ADD) && !out_full_ff;
            cmd.set_serving = (mode_ff == MODE_SERVE);
            cmd.out_load    = !out_full_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         mode_ff     <= MODE_ADD;
         out_full_ff <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) out_full_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  mode_ff <= mode_type'(req_mode);
                  priority if (mode_type'(req_mode) == MODE_ADD) state_ff <= ST_DUP;
                  else if (mode_type'(req_mode) == MODE_QUERY) state_ff <= ST_SRV_START;
                  else state_ff <= ST_FINISH;
               end
            end
            ST_DUP:        if (stat.scan_end) state_ff <= ST_FINISH;
            ST_SRV_START:  state_ff <= ST_SRV_WAIT;
            ST_SRV_WAIT:   if (stat.dist_done) state_ff <= ST_SCAN_START;
            ST_SCAN_START: state_ff <= stat.scan_end ? ST_FINISH : ST_SCAN_WAIT;
            ST_SCAN_WAIT:  if (stat.dist_done) state_ff <= ST_SCAN_START;
            ST_FINISH: begin
               // one result register: wait until the previous item is taken
               if (!out_full_ff) begin
                  out_full_ff <= 1'b1;
                  state_ff    <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

[design/nearest_station_handover_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_station_handover_table
// Ring table of stations with a serving station; queries report handover need
// and the nearest stored station strictly nearer than the serving one, the lowest
// slot winning a tie.
// One item at a time; the next item is taken once the result register is loaded.
// Synchronous reset clears counts, cursor and serving station and sets the threshold to 100.
// ----------------------------------------------------------------------------
module nearest_station_handover_table #(
   parameter int TABLE_DEPTH = nsht_pkg::DEFAULT_TABLE_DEPTH,
   parameter int COORD_BITS  = nsht_pkg::DEFAULT_COORD_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [nsht_pkg::MODE_BITS-1:0]        req_mode,
   input  wire logic [nsht_pkg::ID_BITS-1:0]          req_station_id,
   input  wire logic signed [nsht_pkg::POS_BITS-1:0]  req_pos_x,
   input  wire logic signed [nsht_pkg::POS_BITS-1:0]  req_pos_y,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_status,
   output logic                                       rsp_switch_needed,
   output logic                                       rsp_better_found,
   output logic [nsht_pkg::SLOT_BITS-1:0]             rsp_best_slot,
   output logic [nsht_pkg::ID_BITS-1:0]               rsp_best_id,
   output logic signed [nsht_pkg::POS_BITS-1:0]       rsp_best_x,
   output logic signed [nsht_pkg::POS_BITS-1:0]       rsp_best_y,
   output logic [nsht_pkg::DIST_BITS-1:0]             rsp_serving_distance,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [nsht_pkg::DIST_BITS-1:0]        csr_data
);
   import nsht_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic [DIST_BITS-1:0] threshold_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) threshold_ff <= THRESHOLD_RESET;
      else if (csr_valid) threshold_ff <= csr_data;
   end

   nsht_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_mode,
      .rsp_valid, .rsp_ready, .cmd, .stat
   );

   nsht_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .COORD_BITS(COORD_BITS)) u_dp (
      .clock, .reset, .cmd, .stat, .req_mode, .req_station_id, .req_pos_x,
      .req_pos_y, .threshold(threshold_ff), .rsp_status, .rsp_switch_needed,
      .rsp_better_found, .rsp_best_slot, .rsp_best_id, .rsp_best_x, .rsp_best_y,
      .rsp_serving_distance
   );

endmodule
`default_nettype wire
